// ===== sv/atu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atu_pkg
// Shared types and constants for the endpoint address table.
// ----------------------------------------------------------------------------
package atu_pkg;

    localparam int ENTRIES_DEF = 16;

    localparam int KIND_W  = 2;
    localparam int PORT_W  = 16;
    localparam int WORD_W  = 64;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 5;

    // address kinds; "none" and the unused code never match
    localparam logic [KIND_W-1:0] KIND_V4 = 2'd1;
    localparam logic [KIND_W-1:0] KIND_V6 = 2'd2;

    localparam int IN_FIELDS_W  = KIND_W + PORT_W + 3 * WORD_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = SLOT_W + 2 + COUNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // one endpoint; also the table word
    typedef struct packed {
        logic [WORD_W-1:0] ts;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        logic [PORT_W-1:0] port;
        logic [KIND_W-1:0] kind;
    } entry_t;

    // compare unit result for one table entry
    typedef struct packed {
        logic match;
        logic free;
        logic older;
    } cmp_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               evicted;
        logic               hit;
        logic [SLOT_W-1:0]  slot;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

endpackage

// ===== sv/atu_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atu_table
// Entry memory, one write and one registered read port, with per-entry
// valid bits so that unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module atu_table #(
    parameter int ENTRIES = atu_pkg::ENTRIES_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        rd_en,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
    output atu_pkg::entry_t                             rd_entry,
    input  logic                                        wr_en,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] wr_addr,
    input  atu_pkg::entry_t                             wr_entry
);

    atu_pkg::entry_t    mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    atu_pkg::entry_t    rd_data_reg;
    logic               rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== sv/atu_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atu_cmp
// Shared compare unit: checks one table entry against the request.
// ----------------------------------------------------------------------------
module atu_cmp (
    input  atu_pkg::entry_t                  item,
    input  atu_pkg::entry_t                  entry,
    input  logic                             in_window,
    input  logic                             first,
    input  logic [atu_pkg::WORD_W-1:0]       oldest,
    output atu_pkg::cmp_t                    result
);

    localparam int HALF_W = atu_pkg::WORD_W / 2;

    logic key_eq;
    logic v4_eq;
    logic v6_eq;

    assign key_eq = (entry.kind == item.kind) && (entry.port == item.port);
    // IPv4 lives in the upper half of the high word
    assign v4_eq  = (item.kind == atu_pkg::KIND_V4) &&
                    (entry.hi[atu_pkg::WORD_W-1:HALF_W] == item.hi[atu_pkg::WORD_W-1:HALF_W]);
    assign v6_eq  = (item.kind == atu_pkg::KIND_V6) &&
                    (entry.hi == item.hi) && (entry.lo == item.lo);

    always_comb
    begin
        result.match = in_window && key_eq && (v4_eq || v6_eq);
        result.free  = (entry.port == '0);
        result.older = first || (entry.ts <= oldest);
    end

endmodule

// ===== sv/atu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atu_ctrl
// Scan sequencer: walks the table one entry per cycle through the compare
// unit, then picks the slot and writes the request back.
// ----------------------------------------------------------------------------
module atu_ctrl #(
    parameter int ENTRIES = atu_pkg::ENTRIES_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  atu_pkg::entry_t                             in_item,
    output logic                                        rd_en,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
    input  atu_pkg::entry_t                             rd_entry,
    output logic                                        wr_en,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] wr_addr,
    output atu_pkg::entry_t                             wr_entry,
    output logic                                        res_valid,
    input  logic                                        res_ready,
    output atu_pkg::result_t                            res
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX  = IW'(ENTRIES - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(ENTRIES);

    atu_pkg::state_t             state_reg, state_next;
    atu_pkg::entry_t             item_reg;
    logic [IW-1:0]               rd_idx_reg, rd_idx_next;
    logic                        cmp_vld_reg;
    logic [IW-1:0]               cmp_idx_reg;
    logic                        match_found_reg, match_found_next;
    logic [IW-1:0]               match_idx_reg, match_idx_next;
    logic                        free_found_reg, free_found_next;
    logic [IW-1:0]               free_idx_reg, free_idx_next;
    logic [atu_pkg::WORD_W-1:0]  oldest_reg, oldest_next;
    logic [IW-1:0]               best_idx_reg, best_idx_next;
    logic [CW-1:0]               count_reg, count_next;
    atu_pkg::cmp_t               cmp;
    logic                        accept;
    logic                        commit;
    logic [IW-1:0]               slot;
    logic                        was_free;

    atu_cmp u_cmp (
        .item      (item_reg),
        .entry     (rd_entry),
        .in_window (CW'(cmp_idx_reg) < count_reg),
        .first     (cmp_idx_reg == '0),
        .oldest    (oldest_reg),
        .result    (cmp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            atu_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = atu_pkg::ST_SCAN;
                end
            end
            atu_pkg::ST_SCAN:
            begin
                if (rd_idx_reg == LAST_IDX)
                begin
                    state_next = atu_pkg::ST_DRAIN;
                end
            end
            atu_pkg::ST_DRAIN:
            begin
                state_next = atu_pkg::ST_COMMIT;
            end
            atu_pkg::ST_COMMIT:
            begin
                if (res_ready)
                begin
                    state_next = atu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = atu_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        commit   = 1'b0;
        case (state_reg)
            atu_pkg::ST_IDLE:   in_ready = 1'b1;
            atu_pkg::ST_SCAN:   rd_en    = 1'b1;
            atu_pkg::ST_DRAIN:  ;
            atu_pkg::ST_COMMIT: commit   = res_ready;
            default:            ;
        endcase
    end

    assign accept = in_ready && in_valid;

    // match wins, then the first free slot, then the oldest entry
    assign slot     = match_found_reg ? match_idx_reg :
                      (free_found_reg ? free_idx_reg : best_idx_reg);
    assign was_free = match_found_reg ? (item_reg.port == '0) : free_found_reg;

    always_comb
    begin
        rd_idx_next      = rd_idx_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        oldest_next      = oldest_reg;
        best_idx_next    = best_idx_reg;
        count_next       = count_reg;

        if (accept)
        begin
            rd_idx_next      = '0;
            match_found_next = 1'b0;
            free_found_next  = 1'b0;
        end
        if (rd_en && (rd_idx_reg != LAST_IDX))
        begin
            rd_idx_next = rd_idx_reg + 1'b1;
        end
        if (cmp_vld_reg)
        begin
            if (cmp.match && !match_found_reg)
            begin
                match_found_next = 1'b1;
                match_idx_next   = cmp_idx_reg;
            end
            if (cmp.free && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = cmp_idx_reg;
            end
            // ties go to the later index
            if (cmp.older)
            begin
                oldest_next   = rd_entry.ts;
                best_idx_next = cmp_idx_reg;
            end
        end
        if (commit && was_free && (count_reg != FULL_CNT))
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= atu_pkg::ST_IDLE;
            rd_idx_reg      <= '0;
            cmp_vld_reg     <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            count_reg       <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            rd_idx_reg      <= rd_idx_next;
            cmp_vld_reg     <= rd_en;
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
            count_reg       <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
        cmp_idx_reg   <= rd_idx_reg;
        match_idx_reg <= match_idx_next;
        free_idx_reg  <= free_idx_next;
        oldest_reg    <= oldest_next;
        best_idx_reg  <= best_idx_next;
    end

    assign rd_addr  = rd_idx_reg;
    assign wr_en    = commit;
    assign wr_addr  = slot;
    assign wr_entry = item_reg;

    assign res_valid   = commit;
    assign res.slot    = atu_pkg::SLOT_W'(slot);
    assign res.hit     = match_found_reg;
    assign res.evicted = !match_found_reg && !free_found_reg;
    assign res.count   = atu_pkg::COUNT_W'(count_next);

endmodule

// ===== sv/address_table_update_oldest_replace.sv =====
`timescale 1ns / 1ps
// The scan reads one table entry per cycle through the single read port and the
// shared compare unit; a new request is taken only after the previous one has
// been written back, which waits until the output register can take its result;
// a result held in the output register does not block the next request.
// Reset: asynchronous, clears the valid bits of all entries (reading as free,
// all zero) and the occupied count at once; no clearing pass.
// ----------------------------------------------------------------------------
// address_table_update_oldest_replace
// Endpoint table update with match, first-free or oldest-entry replacement.
// ----------------------------------------------------------------------------
module address_table_update_oldest_replace #(
    parameter int ENTRIES = atu_pkg::ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // kind[1:0], port[17:2], addr_hi[81:18], addr_lo[145:82],
    // time_stamp[209:146], zero pad above
    input  logic [atu_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // slot[3:0], hit[4], evicted[5], valid_count[10:6], zero pad above
    output logic [atu_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    atu_pkg::entry_t  in_item;
    atu_pkg::entry_t  rd_entry;
    atu_pkg::entry_t  wr_entry;
    logic             rd_en;
    logic [IW-1:0]    rd_addr;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    logic             res_valid;
    logic             res_ready;
    atu_pkg::result_t res;
    atu_pkg::result_t m_data_reg;
    logic             m_valid_reg;

    assign in_item.kind = s_axis_tdata[1:0];
    assign in_item.port = s_axis_tdata[17:2];
    assign in_item.hi   = s_axis_tdata[81:18];
    assign in_item.lo   = s_axis_tdata[145:82];
    assign in_item.ts   = s_axis_tdata[209:146];

    atu_table #(
        .ENTRIES (ENTRIES)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry)
    );

    atu_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_entry  (rd_entry),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_entry  (wr_entry),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register
    assign res_ready = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_data_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = atu_pkg::OUT_TDATA_W'(m_data_reg);

endmodule

// ===== sv/atu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atu_checker
// Port-level checks for the endpoint address table.
// ----------------------------------------------------------------------------
module atu_checker #(
    parameter int ENTRIES = atu_pkg::ENTRIES_DEF
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [atu_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [atu_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam logic [atu_pkg::COUNT_W-1:0] FULL_CNT = atu_pkg::COUNT_W'(ENTRIES);

    logic s_fire;
    assign s_fire = s_axis_tvalid && s_axis_tready;

    // a request blocks the input; this check covers only the start of the scan
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready)
        else $error("input ready too soon after a request");

    a_hit_excl_evict: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[4] && m_axis_tdata[5]))
        else $error("hit and evicted both set");

    // eviction only when every slot holds a port, so the count is saturated
    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[5]) |-> (m_axis_tdata[10:6] == FULL_CNT))
        else $error("eviction with table not full");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

endmodule

bind address_table_update_oldest_replace atu_checker #(
    .ENTRIES (ENTRIES)
) u_atu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
